FILE: sv/page_ownership_tag_table_defines.svh
// Assertion macros used by the tag walker of the page ownership tag table.
`ifndef PAGE_OWNERSHIP_TAG_TABLE_DEFINES_SVH
`define PAGE_OWNERSHIP_TAG_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define PAGT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define PAGT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pagt_pkg.sv
// Shared types, codes and defaults of the page ownership tag table.
package pagt_pkg;

    localparam int DEF_MAX_PAGES   = 65536;
    localparam int DEF_FRAME_WIDTH = 44;

    localparam int BASE_CFG_W  = 44;
    localparam int PAGES_CFG_W = 17;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 44;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    // 0x80000000 shifted down by the 4 KiB page size
    localparam logic [BASE_CFG_W-1:0]  RESET_BASE_FRAME = 44'd524288;
    localparam logic [PAGES_CFG_W-1:0] RESET_TRACKED    = 17'd65536;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_FRAME = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACKED    = 8'd1;

    localparam logic [2:0] OP_INIT        = 3'd0;
    localparam logic [2:0] OP_SET_PRIVATE = 3'd1;
    localparam logic [2:0] OP_SET_PUBLIC  = 3'd2;
    localparam logic [2:0] OP_SET_SHARED  = 3'd3;
    localparam logic [2:0] OP_ANY_PRIVATE = 3'd4;
    localparam logic [2:0] OP_ALL_PUBSHR  = 3'd5;

    localparam logic [1:0] TAG_PRIVATE = 2'd0;
    localparam logic [1:0] TAG_SHARED  = 2'd1;
    localparam logic [1:0] TAG_PUBLIC  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_BELOW     = 2'd2;
    localparam logic [1:0] STATUS_PAST_END  = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,   // result only, no tag access
        KIND_FILL = 2'd1,   // write one tag over the range
        KIND_SCAN = 2'd2    // read the range looking for private tags
    } work_kind_t;

    typedef struct packed {
        work_kind_t  kind;
        logic [1:0]  tag;
        logic [1:0]  status;
        logic        want_any;
    } cmd_ctrl_t;

endpackage

FILE: sv/pagt_front.sv
// Command front end: configuration, range checks and work classification.
module pagt_front #(
    parameter int MAX_PAGES   = pagt_pkg::DEF_MAX_PAGES,
    parameter int FRAME_WIDTH = pagt_pkg::DEF_FRAME_WIDTH,
    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    localparam int CNT_W  = $clog2(MAX_PAGES + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pagt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pagt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [2:0]                        cmd_operation,
    input  logic [FRAME_WIDTH-1:0]            cmd_start_frame,
    input  logic [FRAME_WIDTH-1:0]            cmd_page_count,
    output logic                              push_valid,
    input  logic                              push_ready,
    output pagt_pkg::cmd_ctrl_t               push_ctrl,
    output logic [PAGE_W-1:0]                 push_offset,
    output logic [CNT_W-1:0]                  push_count
);

    localparam int WIDE_W = (FRAME_WIDTH > CNT_W) ? FRAME_WIDTH : CNT_W;
    localparam int CMP_W  = ((WIDE_W > pagt_pkg::PAGES_CFG_W) ? WIDE_W
                                                              : pagt_pkg::PAGES_CFG_W) + 1;

    typedef enum logic [1:0] {
        F_IDLE  = 2'd0,
        F_SUB   = 2'd1,
        F_RANGE = 2'd2
    } front_state_t;

    front_state_t                       state_reg, state_next;
    logic                               ready_flag_reg, ready_flag_next;
    logic [pagt_pkg::BASE_CFG_W-1:0]    base_reg, base_next;
    logic [pagt_pkg::PAGES_CFG_W-1:0]   tracked_reg, tracked_next;
    logic [2:0]                         op_reg, op_next;
    logic [FRAME_WIDTH-1:0]             start_reg, start_next;
    logic [FRAME_WIDTH-1:0]             count_reg, count_next;
    logic [FRAME_WIDTH-1:0]             offset_reg, offset_next;
    logic                               below_reg, below_next;

    logic [FRAME_WIDTH-1:0] base_fw;
    logic [CMP_W-1:0]       tracked_ext;
    logic [CMP_W-1:0]       max_ext;
    logic [CMP_W-1:0]       limit_ext;
    logic [CMP_W-1:0]       range_end;
    logic [CNT_W-1:0]       limit;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_RANGE);

    assign base_fw     = FRAME_WIDTH'(base_reg);
    assign tracked_ext = CMP_W'(tracked_reg);
    assign max_ext     = CMP_W'(MAX_PAGES);
    assign limit_ext   = (tracked_ext > max_ext) ? max_ext : tracked_ext;
    assign limit       = CNT_W'(limit_ext);
    assign range_end   = CMP_W'(offset_reg) + CMP_W'(count_reg);

    // Classify the checked command into a work item for the back end.
    always_comb begin
        push_ctrl.kind     = pagt_pkg::KIND_NONE;
        push_ctrl.tag      = pagt_pkg::TAG_PUBLIC;
        push_ctrl.status   = pagt_pkg::STATUS_OK;
        push_ctrl.want_any = 1'b0;
        push_offset        = PAGE_W'(offset_reg);
        push_count         = CNT_W'(count_reg);
        if (op_reg == pagt_pkg::OP_INIT) begin
            push_ctrl.kind = pagt_pkg::KIND_FILL;
            push_offset    = '0;
            push_count     = limit;
        end else if (op_reg > pagt_pkg::OP_ALL_PUBSHR) begin
            push_ctrl.kind = pagt_pkg::KIND_NONE;
        end else if (!ready_flag_reg) begin
            push_ctrl.status = pagt_pkg::STATUS_NOT_READY;
        end else if (below_reg) begin
            push_ctrl.status = pagt_pkg::STATUS_BELOW;
        end else if (range_end > limit_ext) begin
            push_ctrl.status = pagt_pkg::STATUS_PAST_END;
        end else begin
            case (op_reg)
                pagt_pkg::OP_SET_PRIVATE: begin
                    push_ctrl.kind = pagt_pkg::KIND_FILL;
                    push_ctrl.tag  = pagt_pkg::TAG_PRIVATE;
                end
                pagt_pkg::OP_SET_PUBLIC: begin
                    push_ctrl.kind = pagt_pkg::KIND_FILL;
                    push_ctrl.tag  = pagt_pkg::TAG_PUBLIC;
                end
                pagt_pkg::OP_SET_SHARED: begin
                    push_ctrl.kind = pagt_pkg::KIND_FILL;
                    push_ctrl.tag  = pagt_pkg::TAG_SHARED;
                end
                pagt_pkg::OP_ANY_PRIVATE: begin
                    push_ctrl.kind     = pagt_pkg::KIND_SCAN;
                    push_ctrl.want_any = 1'b1;
                end
                default: begin
                    push_ctrl.kind = pagt_pkg::KIND_SCAN;
                end
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        ready_flag_next = ready_flag_reg;
        base_next       = base_reg;
        tracked_next    = tracked_reg;
        op_next         = op_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        below_next      = below_reg;

        if (cfg_valid) begin
            if (cfg_index == pagt_pkg::REG_BASE_FRAME) begin
                base_next = cfg_data[pagt_pkg::BASE_CFG_W-1:0];
            end else if (cfg_index == pagt_pkg::REG_TRACKED) begin
                tracked_next = cfg_data[pagt_pkg::PAGES_CFG_W-1:0];
            end
        end

        case (state_reg)
            F_IDLE: begin
                if (cmd_valid) begin
                    op_next    = cmd_operation;
                    start_next = cmd_start_frame;
                    count_next = cmd_page_count;
                    state_next = F_SUB;
                end
            end
            F_SUB: begin
                below_next  = (start_reg < base_fw);
                offset_next = start_reg - base_fw;
                state_next  = F_RANGE;
            end
            F_RANGE: begin
                if (push_ready) begin
                    if (op_reg == pagt_pkg::OP_INIT) begin
                        ready_flag_next = 1'b1;
                    end
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            ready_flag_reg <= 1'b0;
            base_reg       <= pagt_pkg::RESET_BASE_FRAME;
            tracked_reg    <= pagt_pkg::RESET_TRACKED;
        end else begin
            state_reg      <= state_next;
            ready_flag_reg <= ready_flag_next;
            base_reg       <= base_next;
            tracked_reg    <= tracked_next;
        end
        op_reg     <= op_next;
        start_reg  <= start_next;
        count_reg  <= count_next;
        offset_reg <= offset_next;
        below_reg  <= below_next;
    end

endmodule

FILE: sv/pagt_queue.sv
// Short work queue between the front end and the tag walker.
module pagt_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (pagt_pkg::QUEUE_DEPTH > 1) ? $clog2(pagt_pkg::QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(pagt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pagt_pkg::QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [pagt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FILL_W'(pagt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/pagt_back.sv
// Tag walker: tag memory, range fill and scan, result register.
`include "page_ownership_tag_table_defines.svh"

module pagt_back #(
    parameter int MAX_PAGES = pagt_pkg::DEF_MAX_PAGES,
    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
    localparam int CNT_W  = $clog2(MAX_PAGES + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    output logic                            pop,
    input  pagt_pkg::cmd_ctrl_t             pop_ctrl,
    input  logic [PAGE_W-1:0]               pop_offset,
    input  logic [CNT_W-1:0]                pop_count,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pagt_pkg::M_TDATA_W-1:0]  m_tdata
);

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_WALK  = 2'd1,
        B_DRAIN = 2'd2,
        B_DONE  = 2'd3
    } back_state_t;

    back_state_t         state_reg, state_next;
    pagt_pkg::cmd_ctrl_t ctrl_reg, ctrl_next;
    logic [PAGE_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                found_reg, found_next;
    logic                rd_pend_reg;
    logic [1:0]          rd_data_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [1:0]          status_reg, status_next;
    logic                answer_reg, answer_next;

    logic [1:0] tag_mem [MAX_PAGES];

    logic walking;
    logic mem_we;
    logic mem_re;

    assign walking = (state_reg == B_WALK) && (cnt_reg != '0);
    assign mem_we  = walking && (ctrl_reg.kind == pagt_pkg::KIND_FILL);
    assign mem_re  = walking && (ctrl_reg.kind == pagt_pkg::KIND_SCAN);
    assign pop     = (state_reg == B_IDLE) && pop_valid;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(pagt_pkg::M_TDATA_W - 3){1'b0}}, answer_reg, status_reg};

    always_comb begin
        state_next    = state_reg;
        ctrl_next     = ctrl_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        answer_next   = answer_reg;

        // the read issued in the previous cycle is checked here
        if (rd_pend_reg && (rd_data_reg == pagt_pkg::TAG_PRIVATE)) begin
            found_next = 1'b1;
        end

        case (state_reg)
            B_IDLE: begin
                if (pop_valid) begin
                    ctrl_next  = pop_ctrl;
                    addr_next  = pop_offset;
                    cnt_next   = pop_count;
                    found_next = 1'b0;
                    state_next = (pop_ctrl.kind == pagt_pkg::KIND_NONE) ? B_DONE : B_WALK;
                end
            end
            B_WALK: begin
                if (cnt_reg != '0) begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end else begin
                    state_next = (ctrl_reg.kind == pagt_pkg::KIND_SCAN) ? B_DRAIN : B_DONE;
                end
            end
            B_DRAIN: begin
                state_next = B_DONE;
            end
            B_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    status_next   = ctrl_reg.status;
                    answer_next   = 1'b0;
                    if (ctrl_reg.kind == pagt_pkg::KIND_SCAN) begin
                        answer_next = ctrl_reg.want_any ? found_reg : !found_reg;
                    end
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_pend_reg  <= mem_re;
        end
        ctrl_reg   <= ctrl_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[addr_reg] <= ctrl_reg.tag;
        end
        if (mem_re) begin
            rd_data_reg <= tag_mem[addr_reg];
        end
    end

    `PAGT_ASSERT_NEXT(a_walk_counts_down, walking, cnt_reg == $past(cnt_reg) - 1'b1, "walk count did not step down")
    `PAGT_ASSERT_NOW(a_read_only_in_scan, rd_pend_reg, ctrl_reg.kind == pagt_pkg::KIND_SCAN, "tag read outside a scan")
    `PAGT_ASSERT_NOW(a_pop_only_idle, pop, state_reg == B_IDLE, "queue popped while busy")
    `PAGT_ASSERT_NOW(a_error_no_answer, m_tvalid_reg && (status_reg != pagt_pkg::STATUS_OK), answer_reg == 1'b0, "answer set on a failed command")

endmodule

FILE: sv/page_ownership_tag_table.sv
// Top level of the page ownership tag table: front end, work queue, tag walker.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  operation, start_frame, page_count
//   m_        out        m_tvalid / m_tready  status, answer
//   cfg_      in         cfg_valid/cfg_ready  register index, write data
//
// Each command passes the front end through capture, base subtract and range
// compare, then the walker steps one tag per cycle through the single memory
// port, with a drain step after a query; init walks every tracked page, and a
// failed check or an unused code skips the walk.
// The two-entry queue lets the front end check the next commands while the
// walker is busy; the result register lets the walker wait on m_tready alone.
// aresetn (synchronous) clears the ready flag and restores the registers;
// tags stay undefined until init. cfg_ready is always high.
module page_ownership_tag_table #(
    parameter int MAX_PAGES   = pagt_pkg::DEF_MAX_PAGES,
    parameter int FRAME_WIDTH = pagt_pkg::DEF_FRAME_WIDTH,
    localparam int S_TDATA_W  = ((3 + 2 * FRAME_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation [2:0], start_frame, page_count, zero pad
    input  logic [S_TDATA_W-1:0]              s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], answer [2], zero pad
    output logic [pagt_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pagt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pagt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CTRL_W = $bits(pagt_pkg::cmd_ctrl_t);
    localparam int Q_W    = CTRL_W + PAGE_W + CNT_W;

    // front end to queue
    logic                push_valid;
    logic                push_ready;
    pagt_pkg::cmd_ctrl_t push_ctrl;
    logic [PAGE_W-1:0]   push_offset;
    logic [CNT_W-1:0]    push_count;

    // queue to walker
    logic                pop_valid;
    logic                pop;
    logic [Q_W-1:0]      pop_data;
    pagt_pkg::cmd_ctrl_t pop_ctrl;
    logic [PAGE_W-1:0]   pop_offset;
    logic [CNT_W-1:0]    pop_count;

    // split the queue word back into control, offset and count
    assign pop_ctrl   = pagt_pkg::cmd_ctrl_t'(pop_data[Q_W-1 -: CTRL_W]);
    assign pop_offset = pop_data[CNT_W +: PAGE_W];
    assign pop_count  = pop_data[CNT_W-1:0];

    pagt_front #(
        .MAX_PAGES   (MAX_PAGES),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (s_tvalid),
        .cmd_ready       (s_tready),
        .cmd_operation   (s_tdata[2:0]),
        .cmd_start_frame (s_tdata[3 +: FRAME_WIDTH]),
        .cmd_page_count  (s_tdata[3 + FRAME_WIDTH +: FRAME_WIDTH]),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_ctrl       (push_ctrl),
        .push_offset     (push_offset),
        .push_count      (push_count)
    );

    pagt_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_ctrl, push_offset, push_count}),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    pagt_back #(
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_ctrl   (pop_ctrl),
        .pop_offset (pop_offset),
        .pop_count  (pop_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
